// ===== hdl/grid_square_pack_and_neighbours_assert.svh =====
// assertion macros used by the grid square back end
// expects clk and rst_n in the scope where a macro is used
`ifndef GRID_SQUARE_PACK_AND_NEIGHBOURS_ASSERT_SVH
`define GRID_SQUARE_PACK_AND_NEIGHBOURS_ASSERT_SVH

// same-cycle implication, checked outside reset
`define GSQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define GSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/gsq_pkg.sv =====
// shared types and constants for the grid square packer
// no dependencies
package gsq_pkg;

  localparam int FIELD_COUNT = 18;
  localparam int DIGIT_COUNT = 10;
  localparam int CODE_W      = 15;

  localparam logic [7:0] CHAR_A    = 8'h41;
  localparam logic [7:0] CHAR_R    = 8'h52;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [4:0] FIELD_MAX = 5'(FIELD_COUNT - 1);
  localparam logic [3:0] DIGIT_MAX = 4'(DIGIT_COUNT - 1);

  // neighbour offset codes: one step down, same square, one step up
  localparam logic [1:0] OFS_DOWN = 2'd0;
  localparam logic [1:0] OFS_SAME = 2'd1;
  localparam logic [1:0] OFS_UP   = 2'd2;

  // one classified locator as it travels from front to back
  typedef struct packed {
    logic [4:0] lon_f;
    logic [3:0] lon_d;
    logic [4:0] lat_f;
    logic [3:0] lat_d;
    logic       invalid;
    logic       nbr;
  } gsq_item_t;

  // queue status seen by the back end
  typedef struct packed {
    logic valid;
    logic full;
  } gsq_qstat_t;

endpackage

// ===== hdl/gsq_front.sv =====
// front end: checks the four locator characters and splits them into indices
// depends on gsq_pkg
module gsq_front (
  input  logic            [7:0] in_lon_field_char,
  input  logic            [7:0] in_lat_field_char,
  input  logic            [7:0] in_lon_digit_char,
  input  logic            [7:0] in_lat_digit_char,
  input  logic                  in_with_neighbours,
  output gsq_pkg::gsq_item_t    item
);
  import gsq_pkg::*;

  logic ok_lon_f, ok_lat_f, ok_lon_d, ok_lat_d;

  // character range checks
  always_comb begin
    ok_lon_f = in_lon_field_char inside {[CHAR_A:CHAR_R]};
    ok_lat_f = in_lat_field_char inside {[CHAR_A:CHAR_R]};
    ok_lon_d = in_lon_digit_char inside {[CHAR_ZERO:CHAR_NINE]};
    ok_lat_d = in_lat_digit_char inside {[CHAR_ZERO:CHAR_NINE]};
  end

  // ascii to field and digit indices
  always_comb begin
    item.lon_f   = 5'(in_lon_field_char - CHAR_A);
    item.lat_f   = 5'(in_lat_field_char - CHAR_A);
    item.lon_d   = 4'(in_lon_digit_char - CHAR_ZERO);
    item.lat_d   = 4'(in_lat_digit_char - CHAR_ZERO);
    item.invalid = !(ok_lon_f && ok_lat_f && ok_lon_d && ok_lat_d);
    item.nbr     = in_with_neighbours;
  end

endmodule

// ===== hdl/gsq_queue.sv =====
// two-entry queue between front and back end
// depends on gsq_pkg
module gsq_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  gsq_pkg::gsq_item_t push_item,
  input  logic               pop,
  output gsq_pkg::gsq_item_t head_item,
  output gsq_pkg::gsq_qstat_t stat
);
  import gsq_pkg::*;

  gsq_item_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // head and status
  always_comb begin
    head_item  = mem_r[rd_ptr_r];
    stat.valid = (count_r != 2'd0);
    stat.full  = (count_r == 2'd2);
  end

endmodule

// ===== hdl/gsq_back.sv =====
// back end: walks the neighbour block of one item and drives the result register
// depends on gsq_pkg and the assertion macro header
module gsq_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gsq_pkg::gsq_item_t                q_item,
  input  gsq_pkg::gsq_qstat_t               q_stat,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [gsq_pkg::CODE_W-1:0]        out_square_code,
  output logic                              out_invalid,
  output logic                              out_last
);
  import gsq_pkg::*;
  `include "grid_square_pack_and_neighbours_assert.svh"

  gsq_item_t         item_r, item_nxt;
  logic              active_r, active_nxt;
  logic [1:0]        dlon_r, dlon_nxt;
  logic [1:0]        dlat_r, dlat_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic              inv_r, inv_nxt;
  logic              last_r, last_nxt;

  logic              advance, load, is_last;
  logic [1:0]        lat_lo, lat_hi;
  logic [4:0]        cur_lon_f, cur_lat_f;
  logic [3:0]        cur_lon_d, cur_lat_d;
  logic [CODE_W-1:0] cur_code;

  // first latitude offset of the walk, skipping the row below the south pole
  function automatic logic [1:0] lat_low_ofs(gsq_item_t it);
    logic south;
    south = (it.lat_f == 5'd0) && (it.lat_d == 4'd0);
    return south ? OFS_SAME : OFS_DOWN;
  endfunction

  // last latitude offset of the walk, skipping the row above the north pole
  function automatic logic [1:0] lat_high_ofs(gsq_item_t it);
    logic north;
    north = (it.lat_f == FIELD_MAX) && (it.lat_d == DIGIT_MAX);
    return north ? OFS_SAME : OFS_UP;
  endfunction

  // walk bounds and end of run
  always_comb begin
    lat_lo  = lat_low_ofs(item_r);
    lat_hi  = lat_high_ofs(item_r);
    is_last = !item_r.nbr || item_r.invalid || (dlon_r == OFS_UP && dlat_r == lat_hi);
  end

  // longitude of the current square, wrapping across the antimeridian
  always_comb begin
    cur_lon_f = item_r.lon_f;
    cur_lon_d = item_r.lon_d;
    case (dlon_r)
      OFS_DOWN: begin
        if (item_r.lon_d == 4'd0) begin
          cur_lon_d = DIGIT_MAX;
          cur_lon_f = (item_r.lon_f == 5'd0) ? FIELD_MAX : item_r.lon_f - 5'd1;
        end else begin
          cur_lon_d = item_r.lon_d - 4'd1;
        end
      end
      OFS_UP: begin
        if (item_r.lon_d == DIGIT_MAX) begin
          cur_lon_d = 4'd0;
          cur_lon_f = (item_r.lon_f == FIELD_MAX) ? 5'd0 : item_r.lon_f + 5'd1;
        end else begin
          cur_lon_d = item_r.lon_d + 4'd1;
        end
      end
      default: begin
        cur_lon_f = item_r.lon_f;
        cur_lon_d = item_r.lon_d;
      end
    endcase
  end

  // latitude of the current square, never past a pole thanks to the walk bounds
  always_comb begin
    cur_lat_f = item_r.lat_f;
    cur_lat_d = item_r.lat_d;
    case (dlat_r)
      OFS_DOWN: begin
        if (item_r.lat_d == 4'd0) begin
          cur_lat_d = DIGIT_MAX;
          cur_lat_f = item_r.lat_f - 5'd1;
        end else begin
          cur_lat_d = item_r.lat_d - 4'd1;
        end
      end
      OFS_UP: begin
        if (item_r.lat_d == DIGIT_MAX) begin
          cur_lat_d = 4'd0;
          cur_lat_f = item_r.lat_f + 5'd1;
        end else begin
          cur_lat_d = item_r.lat_d + 4'd1;
        end
      end
      default: begin
        cur_lat_f = item_r.lat_f;
        cur_lat_d = item_r.lat_d;
      end
    endcase
  end

  // pack into the square code
  always_comb begin
    cur_code = CODE_W'(cur_lon_f) * CODE_W'(FIELD_COUNT * DIGIT_COUNT * DIGIT_COUNT)
             + CODE_W'(cur_lat_f) * CODE_W'(DIGIT_COUNT * DIGIT_COUNT)
             + CODE_W'(cur_lon_d) * CODE_W'(DIGIT_COUNT)
             + CODE_W'(cur_lat_d);
  end

  // walk control and result register
  always_comb begin
    advance       = !out_valid_r || !out_stall;
    active_nxt    = active_r;
    item_nxt      = item_r;
    dlon_nxt      = dlon_r;
    dlat_nxt      = dlat_r;
    out_valid_nxt = out_valid_r;
    code_nxt      = code_r;
    inv_nxt       = inv_r;
    last_nxt      = last_r;
    load          = 1'b0;

    if (advance) begin
      out_valid_nxt = active_r;
    end

    if (active_r) begin
      if (advance) begin
        code_nxt = item_r.invalid ? '0 : cur_code;
        inv_nxt  = item_r.invalid;
        last_nxt = is_last;
        if (is_last) begin
          active_nxt = q_stat.valid;
          load       = q_stat.valid;
        end else if (dlat_r == lat_hi) begin
          dlon_nxt = dlon_r + 2'd1;
          dlat_nxt = lat_lo;
        end else begin
          dlat_nxt = dlat_r + 2'd1;
        end
      end
    end else begin
      active_nxt = q_stat.valid;
      load       = q_stat.valid;
    end

    // take the next item from the queue
    if (load) begin
      item_nxt = q_item;
      if (q_item.nbr && !q_item.invalid) begin
        dlon_nxt = OFS_DOWN;
        dlat_nxt = lat_low_ofs(q_item);
      end else begin
        dlon_nxt = OFS_SAME;
        dlat_nxt = OFS_SAME;
      end
    end
    pop = load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      dlon_r      <= OFS_SAME;
      dlat_r      <= OFS_SAME;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      dlon_r      <= dlon_nxt;
      dlat_r      <= dlat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    code_r <= code_nxt;
    inv_r  <= inv_nxt;
    last_r <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_square_code = code_r;
  assign out_invalid     = inv_r;
  assign out_last        = last_r;

  // checks
  `GSQ_ASSERT_NOW(a_invalid_single, out_valid_r && inv_r, last_r && code_r == '0, "invalid result not a single zero beat")
  `GSQ_ASSERT_NOW(a_walk_in_bounds, active_r, dlat_r >= lat_lo && dlat_r <= lat_hi && dlon_r <= OFS_UP, "neighbour walk out of bounds")
  `GSQ_ASSERT_NOW(a_code_range, out_valid_r, code_r <= CODE_W'(32399), "square code out of range")

endmodule

// ===== hdl/grid_square_pack_and_neighbours.sv =====
// top level of the maidenhead square packer with 3x3 neighbour output
// depends on gsq_pkg, gsq_front, gsq_queue and gsq_back
//
//   channel  | handshake            | beat contents
//   ---------+----------------------+-------------------------------------------
//   input    | in_valid / in_stall  | four locator characters, neighbour flag
//   result   | out_valid / out_stall| square code, invalid flag, last flag
//
// one result beat per cycle from the back-end walker unless out_stall holds it: a square-only
// or invalid item gives one beat, a neighbour item nine beats, or six in a polar row.
// a two-entry queue lets new items in while the walker works; in_stall rises when it is full.
// an idle walker loads the queue head into its item register, then drives the result register.
// synchronous active-low reset clears the queue, the walker and out_valid.
// out_stall with out_valid high holds the result register and the walk; idle loads go on.
module grid_square_pack_and_neighbours (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_lon_field_char,
  input  logic [7:0]                 in_lat_field_char,
  input  logic [7:0]                 in_lon_digit_char,
  input  logic [7:0]                 in_lat_digit_char,
  input  logic                       in_with_neighbours,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [gsq_pkg::CODE_W-1:0] out_square_code,
  output logic                       out_invalid,
  output logic                       out_last
);
  import gsq_pkg::*;

  gsq_item_t  front_item;
  gsq_item_t  head_item;
  gsq_qstat_t q_stat;
  logic       push, pop;

  // classify incoming locator
  gsq_front u_front (
    .in_lon_field_char  (in_lon_field_char),
    .in_lat_field_char  (in_lat_field_char),
    .in_lon_digit_char  (in_lon_digit_char),
    .in_lat_digit_char  (in_lat_digit_char),
    .in_with_neighbours (in_with_neighbours),
    .item               (front_item)
  );

  // intake handshake
  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  gsq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .head_item (head_item),
    .stat      (q_stat)
  );

  gsq_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_item          (head_item),
    .q_stat          (q_stat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_square_code (out_square_code),
    .out_invalid     (out_invalid),
    .out_last        (out_last)
  );

endmodule

// ===== verif/tb_grid_square_pack_and_neighbours.sv =====
// self-checking testbench for grid_square_pack_and_neighbours
// depends on gsq_pkg and the block's rtl; drives locator beats, predicts square code beats
// a table of directed locators runs first, then random locators with random gaps and stalls
module tb_grid_square_pack_and_neighbours;
  import gsq_pkg::*;

  // one locator beat as driven on the input channel
  typedef struct packed {
    logic [7:0] lon_f;
    logic [7:0] lat_f;
    logic [7:0] lon_d;
    logic [7:0] lat_d;
    logic       nbr;
  } locator_t;

  // one square code beat as seen on the result channel
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              bad;
    logic              last;
  } square_beat_t;

  // directed row: typed rows carry their single result beat
  typedef struct packed {
    locator_t          loc;
    logic              typed;
    logic              bad;
    logic [CODE_W-1:0] code;
  } locator_row_t;

  localparam int N_DIRECTED = 24;
  localparam int N_RANDOM   = 126;
  localparam int AXIS       = FIELD_COUNT * DIGIT_COUNT;

  localparam locator_row_t DIRECTED [N_DIRECTED] = '{
    // square only, corners of the grid and one interior square
    '{'{"A", "A", "0", "0", 1'b0}, 1'b1, 1'b0, 15'd0},
    '{'{"R", "R", "9", "9", 1'b0}, 1'b1, 1'b0, 15'd32399},
    '{'{"R", "A", "9", "0", 1'b0}, 1'b1, 1'b0, 15'd30690},
    '{'{"A", "R", "0", "9", 1'b0}, 1'b1, 1'b0, 15'd1709},
    '{'{"J", "N", "5", "8", 1'b0}, 1'b0, 1'b0, 15'd0},
    // characters just outside their ranges, lower case, all-zero bytes, first char a digit
    '{'{"a", "A", "0", "0", 1'b0}, 1'b1, 1'b1, 15'd0},
    '{'{"A", "@", "0", "0", 1'b0}, 1'b1, 1'b1, 15'd0},
    '{'{"A", "S", "0", "0", 1'b0}, 1'b1, 1'b1, 15'd0},
    '{'{"A", "A", "/", "0", 1'b0}, 1'b1, 1'b1, 15'd0},
    '{'{"A", "A", "0", ":", 1'b0}, 1'b1, 1'b1, 15'd0},
    '{'{8'h00, 8'h00, 8'h00, 8'h00, 1'b0}, 1'b1, 1'b1, 15'd0},
    '{'{"0", "A", "0", "0", 1'b0}, 1'b1, 1'b1, 15'd0},
    // invalid in neighbour mode still gives one beat
    '{'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1}, 1'b1, 1'b1, 15'd0},
    '{'{"r", "r", "9", "9", 1'b1}, 1'b1, 1'b1, 15'd0},
    // polar rows with longitude wrap
    '{'{"A", "A", "0", "0", 1'b1}, 1'b0, 1'b0, 15'd0},
    '{'{"R", "R", "9", "9", 1'b1}, 1'b0, 1'b0, 15'd0},
    '{'{"A", "R", "0", "9", 1'b1}, 1'b0, 1'b0, 15'd0},
    '{'{"R", "A", "9", "0", 1'b1}, 1'b0, 1'b0, 15'd0},
    // interior squares, most with field boundaries crossed by the neighbours
    '{'{"J", "N", "5", "8", 1'b1}, 1'b0, 1'b0, 15'd0},
    '{'{"J", "J", "0", "9", 1'b1}, 1'b0, 1'b0, 15'd0},
    '{'{"A", "B", "0", "0", 1'b1}, 1'b0, 1'b0, 15'd0},
    '{'{"R", "A", "9", "9", 1'b1}, 1'b0, 1'b0, 15'd0},
    // one row off the pole gives the full block
    '{'{"A", "A", "0", "1", 1'b1}, 1'b0, 1'b0, 15'd0},
    '{'{"R", "R", "9", "8", 1'b1}, 1'b0, 1'b0, 15'd0}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        in_lon_field_char = 8'h00;
  logic [7:0]        in_lat_field_char = 8'h00;
  logic [7:0]        in_lon_digit_char = 8'h00;
  logic [7:0]        in_lat_digit_char = 8'h00;
  logic              in_with_neighbours = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CODE_W-1:0] out_square_code;
  logic              out_invalid;
  logic              out_last;

  square_beat_t expected_squares[$];
  square_beat_t head_beat;
  int error_count = 0;
  int beat_count = 0;
  int locator_count = 0;
  int nbr_count = 0;
  int polar_count = 0;
  int bad_count = 0;
  int stall_left = 0;

  grid_square_pack_and_neighbours DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_lon_field_char  (in_lon_field_char),
    .in_lat_field_char  (in_lat_field_char),
    .in_lon_digit_char  (in_lon_digit_char),
    .in_lat_digit_char  (in_lat_digit_char),
    .in_with_neighbours (in_with_neighbours),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_square_code    (out_square_code),
    .out_invalid        (out_invalid),
    .out_last           (out_last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // watchdog
  initial begin
    #(20 * 400000);
    $display("%0t: timeout, %0d beats still expected", $time, expected_squares.size());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic bit is_letter(logic [7:0] c);
    return c >= CHAR_A && c <= CHAR_R;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CHAR_ZERO && c <= CHAR_NINE;
  endfunction

  function automatic logic [CODE_W-1:0] square_of(int lon_idx, int lat_idx);
    return CODE_W'(((lon_idx / DIGIT_COUNT) * FIELD_COUNT + lat_idx / DIGIT_COUNT)
                   * DIGIT_COUNT * DIGIT_COUNT
                   + (lon_idx % DIGIT_COUNT) * DIGIT_COUNT + lat_idx % DIGIT_COUNT);
  endfunction

  // gap length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(15, 30);
  endfunction

  // expected beats for one locator: one beat, or the 3x3 block minus rows past a pole
  task automatic predict_squares(input locator_t loc);
    int lon_idx;
    int lat_idx;
    int lo;
    int la;
    square_beat_t blk[$];
    if (!is_letter(loc.lon_f) || !is_letter(loc.lat_f) ||
        !is_digit(loc.lon_d) || !is_digit(loc.lat_d)) begin
      bad_count++;
      expected_squares.push_back('{CODE_W'(0), 1'b1, 1'b1});
    end else begin
      lon_idx = int'(loc.lon_f - CHAR_A) * DIGIT_COUNT + int'(loc.lon_d - CHAR_ZERO);
      lat_idx = int'(loc.lat_f - CHAR_A) * DIGIT_COUNT + int'(loc.lat_d - CHAR_ZERO);
      if (!loc.nbr) begin
        expected_squares.push_back('{square_of(lon_idx, lat_idx), 1'b0, 1'b1});
      end else begin
        if (lat_idx == 0 || lat_idx == AXIS - 1) polar_count++;
        for (int dlon = -1; dlon <= 1; dlon++) begin
          lo = (lon_idx + AXIS + dlon) % AXIS;
          for (int dlat = -1; dlat <= 1; dlat++) begin
            la = lat_idx + dlat;
            if (la >= 0 && la < AXIS) blk.push_back('{square_of(lo, la), 1'b0, 1'b0});
          end
        end
        blk[blk.size() - 1].last = 1'b1;
        foreach (blk[i]) expected_squares.push_back(blk[i]);
      end
    end
  endtask

  // present one locator beat and hold it until taken
  task automatic send_locator(input locator_t loc);
    in_valid           <= 1'b1;
    in_lon_field_char  <= loc.lon_f;
    in_lat_field_char  <= loc.lat_f;
    in_lon_digit_char  <= loc.lon_d;
    in_lat_digit_char  <= loc.lat_d;
    in_with_neighbours <= loc.nbr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    locator_count++;
    if (loc.nbr) nbr_count++;
  endtask

  task automatic idle_input(input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // random locator: mostly well formed with edge-heavy indexes, the rest broken or noise
  function automatic locator_t random_locator();
    locator_t loc;
    int lon_idx;
    int lat_idx;
    int r;
    int pick;
    logic [7:0] junk;
    r = $urandom_range(0, 99);
    lon_idx = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? AXIS - 1 : 0)
                                          : $urandom_range(0, AXIS - 1);
    lat_idx = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? AXIS - 1 : 0)
                                          : $urandom_range(0, AXIS - 1);
    loc.lon_f = CHAR_A + 8'(lon_idx / DIGIT_COUNT);
    loc.lat_f = CHAR_A + 8'(lat_idx / DIGIT_COUNT);
    loc.lon_d = CHAR_ZERO + 8'(lon_idx % DIGIT_COUNT);
    loc.lat_d = CHAR_ZERO + 8'(lat_idx % DIGIT_COUNT);
    loc.nbr   = ($urandom_range(0, 9) < 6);
    if (r >= 70 && r < 85) begin
      // one character pushed just past its range or into the wrong class
      pick = $urandom_range(0, 3);
      case ($urandom_range(0, 4))
        0: junk = CHAR_A - 8'd1;
        1: junk = CHAR_R + 8'd1;
        2: junk = CHAR_ZERO - 8'd1;
        3: junk = CHAR_NINE + 8'd1;
        default: junk = 8'($urandom_range(8'h61, 8'h7A));
      endcase
      case (pick)
        0: loc.lon_f = junk;
        1: loc.lat_f = junk;
        2: loc.lon_d = junk;
        default: loc.lat_d = junk;
      endcase
    end else if (r >= 85) begin
      loc.lon_f = 8'($urandom);
      loc.lat_f = 8'($urandom);
      loc.lon_d = 8'($urandom);
      loc.lat_d = 8'($urandom);
      loc.nbr   = 1'($urandom);
    end
    return loc;
  endfunction

  // result side stall: alternating stalled and free stretches of random length
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (out_stall) begin
      out_stall  <= 1'b0;
      stall_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : idle_len();
    end else begin
      out_stall  <= 1'b1;
      stall_left <= idle_len();
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      beat_count++;
      if (expected_squares.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result beat code=%0d invalid=%0b last=%0b",
                 $time, out_square_code, out_invalid, out_last);
      end else begin
        head_beat = expected_squares.pop_front();
        if (out_square_code !== head_beat.code) begin
          error_count++;
          $display("%0t: square_code expected %0d actual %0d",
                   $time, head_beat.code, out_square_code);
        end
        if (out_invalid !== head_beat.bad) begin
          error_count++;
          $display("%0t: invalid expected %0b actual %0b", $time, head_beat.bad, out_invalid);
        end
        if (out_last !== head_beat.last) begin
          error_count++;
          $display("%0t: last expected %0b actual %0b", $time, head_beat.last, out_last);
        end
      end
    end
  end

  // stimulus
  initial begin
    locator_t loc;
    bit burst;
    burst = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_locator(DIRECTED[i].loc);
      if (DIRECTED[i].typed) begin
        if (DIRECTED[i].bad) bad_count++;
        expected_squares.push_back('{DIRECTED[i].code, DIRECTED[i].bad, 1'b1});
      end else begin
        predict_squares(DIRECTED[i].loc);
      end
      idle_input(idle_len());
    end

    // random locators, with back-to-back stretches now and then
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 25 == 0) burst = ($urandom_range(0, 2) == 0);
      loc = random_locator();
      send_locator(loc);
      predict_squares(loc);
      idle_input(burst ? 0 : idle_len());
    end
    in_valid <= 1'b0;

    // drain, then watch for stray beats
    while (expected_squares.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d locators (%0d neighbour, %0d polar, %0d invalid), %0d beats checked",
             locator_count, nbr_count, polar_count, bad_count, beat_count);
    $display("random gaps on input, random stalls on output, %0d mismatches", error_count);
    if (error_count == 0 && expected_squares.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
